// ===== rtl/mm9f_pkg.sv =====
// ---------------------------------------------------------------------------
// mm9f_pkg
// Shared types, constants and the median-of-9 exchange network used by the
// multichannel median filter core.
// ---------------------------------------------------------------------------
package mm9f_pkg;

   localparam int CHANNELS    = 12;
   localparam int SAMPLE_BITS = 12;
   localparam int TAPS        = 9;

   localparam int CH_BITS     = 4;
   localparam int SMP_BITS    = 12;
   localparam int TAP_BITS    = $clog2(TAPS + 1);
   localparam int MEM_DEPTH   = CHANNELS * TAPS;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);
   // address over the whole channel field range, so a bad channel cannot wrap
   localparam int FULL_AW     = CH_BITS + TAP_BITS;

   localparam int NET_SIZE    = 19;
   localparam int SORT_STAGES = 3;
   localparam int STAGE_BITS  = $clog2(SORT_STAGES);

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [TAPS-1:0]  taps_type;

   typedef struct packed {
      logic                command;
      logic [CH_BITS-1:0]  channel;
      logic [SMP_BITS-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic [SMP_BITS-1:0] median;
      logic [CH_BITS-1:0]  channel_out;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SETTLE,
      ST_SORT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic                  store_en;
      logic                  query_start;
      logic                  rd_en;
      logic [TAP_BITS-1:0]   rd_tap;
      logic                  sort_en;
      logic [STAGE_BITS-1:0] sort_stage;
      logic                  rsp_en;
   } ctrl_cmd_type;

   // exchange pairs: the low index ends up holding the smaller value
   localparam logic [3:0] NET_LO [NET_SIZE] = '{
      4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7,
      4'd0, 4'd5, 4'd4, 4'd3, 4'd1, 4'd2,
      4'd4, 4'd4, 4'd6, 4'd4};
   localparam logic [3:0] NET_HI [NET_SIZE] = '{
      4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8,
      4'd3, 4'd8, 4'd7, 4'd6, 4'd4, 4'd5,
      4'd7, 4'd2, 4'd4, 4'd2};
   // which clock step runs each exchange (three layers, two layers, four)
   localparam logic [STAGE_BITS-1:0] NET_STAGE [NET_SIZE] = '{
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
      2'd2, 2'd2, 2'd2, 2'd2};

   function automatic taps_type sort_stage(taps_type v_in,
                                           logic [STAGE_BITS-1:0] stage);
      taps_type   v;
      sample_type t;
      v = v_in;
      for (int i = 0; i < NET_SIZE; i++) begin
         if (NET_STAGE[i] == stage && v[NET_LO[i]] > v[NET_HI[i]]) begin
            t            = v[NET_LO[i]];
            v[NET_LO[i]] = v[NET_HI[i]];
            v[NET_HI[i]] = t;
         end
      end
      return v;
   endfunction

endpackage

// ===== rtl/mm9f_ctrl.sv =====
// ---------------------------------------------------------------------------
// mm9f_ctrl
// Command sequencer: takes items, walks a query through nine reads, a
// settle step, the three network steps and the reply.
// ---------------------------------------------------------------------------
module mm9f_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mm9f_pkg::req_item_type req_item,
   output logic                   busy,
   output mm9f_pkg::ctrl_cmd_type cmd
);
   import mm9f_pkg::*;

   state_type           state_ff, state_in;
   logic [TAP_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.command == CMD_QUERY) begin
                  cmd.query_start = 1'b1;
                  cnt_in          = '0;
                  state_in        = ST_READ;
               end else begin
                  cmd.store_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tap = cnt_ff;
            if (cnt_ff == TAP_BITS'(TAPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SETTLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SETTLE: begin
            // last read word is shifted in here
            cnt_in   = '0;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            cmd.sort_en    = 1'b1;
            cmd.sort_stage = cnt_ff[STAGE_BITS-1:0];
            if (cnt_ff == TAP_BITS'(SORT_STAGES - 1)) begin
               cnt_in   = '0;
               state_in = ST_REPLY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_REPLY: begin
            cmd.rsp_en = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/mm9f_dpath.sv =====
// ---------------------------------------------------------------------------
// mm9f_dpath
// Sample store with per-entry valid bits, per-channel ring pointers, the
// nine-word load register, the staged exchange network and the result
// register.
// ---------------------------------------------------------------------------
module mm9f_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  mm9f_pkg::req_item_type req_item,
   input  mm9f_pkg::ctrl_cmd_type cmd,
   output logic                   rsp_strobe,
   output mm9f_pkg::rsp_item_type rsp_item
);
   import mm9f_pkg::*;

   sample_type          mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] ent_vld_ff;
   logic [TAP_BITS-1:0] slot_ff [CHANNELS];

   logic [CH_BITS-1:0]  ch_ff;
   sample_type          rd_data_ff;
   logic                rd_vld_ff;
   logic                load_ff;
   taps_type            taps_ff;
   logic                strobe_ff;
   rsp_item_type        rsp_ff;

   logic                wr_ch_ok, rd_ch_ok;
   logic [TAP_BITS-1:0] wr_slot, wr_slot_nxt;
   logic [FULL_AW-1:0]  wr_addr, rd_addr;
   logic [MEM_AW-1:0]   wr_idx, rd_idx;
   logic                wr_en;

   always_comb begin
      wr_ch_ok = (req_item.channel < CH_BITS'(CHANNELS));
      rd_ch_ok = (ch_ff < CH_BITS'(CHANNELS));
      wr_slot  = wr_ch_ok ? slot_ff[req_item.channel] : '0;
      wr_slot_nxt = (wr_slot == TAP_BITS'(TAPS - 1)) ? '0 : wr_slot + 1'b1;
      wr_addr  = FULL_AW'(req_item.channel) * FULL_AW'(TAPS) + FULL_AW'(wr_slot);
      rd_addr  = FULL_AW'(ch_ff) * FULL_AW'(TAPS) + FULL_AW'(cmd.rd_tap);
      wr_idx   = wr_addr[MEM_AW-1:0];
      rd_idx   = rd_addr[MEM_AW-1:0];
      wr_en    = cmd.store_en && wr_ch_ok;
   end

   // sample store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= req_item.sample[SAMPLE_BITS-1:0];
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            slot_ff[c] <= '0;
         end
         rd_vld_ff <= 1'b0;
         load_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            ent_vld_ff[wr_idx]        <= 1'b1;
            slot_ff[req_item.channel] <= wr_slot_nxt;
         end
         // a never-written entry or a bad channel reads as zero
         if (cmd.rd_en) begin
            rd_vld_ff <= rd_ch_ok && ent_vld_ff[rd_idx];
         end
         load_ff   <= cmd.rd_en;
         strobe_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         ch_ff <= req_item.channel;
      end
      if (load_ff) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            taps_ff[i] <= taps_ff[i+1];
         end
         taps_ff[TAPS-1] <= rd_vld_ff ? rd_data_ff : '0;
      end else if (cmd.sort_en) begin
         taps_ff <= sort_stage(taps_ff, cmd.sort_stage);
      end
      if (cmd.rsp_en) begin
         rsp_ff.median      <= SMP_BITS'(taps_ff[TAPS/2]);
         rsp_ff.channel_out <= ch_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/multichannel_median9_filter_core.sv =====
// ---------------------------------------------------------------------------
// multichannel_median9_filter_core
// Per-channel nine-sample history with median-of-9 query.
// ---------------------------------------------------------------------------
// Store: taken without going busy, no result; a new item can follow next cycle.
// Query: nine reads from the single store port, a settle step, three
//   network steps and a reply step; busy stays high throughout, and a new
//   item can be taken in the cycle that the strobe is high.
// Results cannot be held off; each query's strobe lasts one cycle.
// Reset (synchronous) clears all valid bits and ring pointers, so every
//   stored sample reads as zero until written.
// ---------------------------------------------------------------------------
module multichannel_median9_filter_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mm9f_pkg::req_item_type req_item,
   output logic                   rsp_strobe,
   output mm9f_pkg::rsp_item_type rsp_item
);
   import mm9f_pkg::*;

   ctrl_cmd_type cmd;

   mm9f_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .cmd      (cmd)
   );

   mm9f_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== verif/tb_multichannel_median9_filter_core.sv =====
// ---------------------------------------------------------------------------
// tb_multichannel_median9_filter_core
// Self-checking bench for the nine-tap median filter core. A shadow copy of
// the per-channel sample rings predicts the median of every query; results
// are matched in order against the expected queue. Directed corner items run
// first, then random store/query sequences with random start gaps.
// ---------------------------------------------------------------------------
module tb_multichannel_median9_filter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mm9f_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 1700;

   class median9_tracker;
      sample_type   history [CHANNELS][TAPS];
      int unsigned  next_slot [CHANNELS];
      rsp_item_type expected_medians [$];
      int unsigned  mismatches;

      function new();
         foreach (history[c, t]) history[c][t] = '0;
         foreach (next_slot[c]) next_slot[c] = 0;
         mismatches = 0;
      endfunction

      // insertion sort of a copy; middle entry is the median
      function sample_type median_of(int unsigned ch);
         sample_type v [TAPS];
         sample_type key;
         int         j;
         foreach (v[i]) v[i] = history[ch][i];
         for (int i = 1; i < TAPS; i++) begin
            key = v[i];
            j   = i - 1;
            while (j >= 0 && v[j] > key) begin
               v[j+1] = v[j];
               j--;
            end
            v[j+1] = key;
         end
         return v[TAPS/2];
      endfunction

      function void note_item(req_item_type it);
         rsp_item_type r;
         if (it.command == CMD_STORE) begin
            if (it.channel < CHANNELS) begin
               history[it.channel][next_slot[it.channel]] = it.sample;
               next_slot[it.channel] = (next_slot[it.channel] == TAPS - 1) ?
                                       0 : next_slot[it.channel] + 1;
            end
         end else begin
            r.channel_out = it.channel;
            r.median      = (it.channel < CHANNELS) ? median_of(it.channel) : '0;
            expected_medians.push_back(r);
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%t MISMATCH: %s", $realtime, msg);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type exp;
         if (expected_medians.size() == 0) begin
            flag($sformatf("unexpected result median=%0d channel=%0d",
                           got.median, got.channel_out));
            return;
         end
         exp = expected_medians.pop_front();
         if (got.median !== exp.median)
            flag($sformatf("median: expected %0d, got %0d (channel %0d)",
                           exp.median, got.median, exp.channel_out));
         if (got.channel_out !== exp.channel_out)
            flag($sformatf("channel_out: expected %0d, got %0d",
                           exp.channel_out, got.channel_out));
      endfunction

      function void check_drained();
         while (expected_medians.size() != 0) begin
            flag($sformatf("missing result for channel %0d",
                           expected_medians[0].channel_out));
            void'(expected_medians.pop_front());
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   median9_tracker tracker;
   int unsigned    idle_cycles;
   int unsigned    items_sent;
   bit             calm;

   multichannel_median9_filter_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // accepted items and results, sampled at the edge that takes them
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) tracker.note_item(req_item);
         if (rsp_strobe) tracker.check_result(rsp_item);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_multichannel_median9_filter_core: done, errors");
            $finish;
         end
      end
   end

   function automatic req_item_type make_item(logic cmd, int unsigned ch,
                                              int unsigned smp);
      req_item_type it;
      it.command = cmd;
      it.channel = ch[CH_BITS-1:0];
      it.sample  = smp[SMP_BITS-1:0];
      return it;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   function automatic int unsigned pick_sample(int unsigned style, int unsigned base);
      case (style)
         0: return $urandom_range(0, 4095);
         1: return $urandom_range(0, 3);
         2: return $urandom_range(4090, 4095);
         3: return base;
         default: return (base + $urandom_range(0, 8)) & 12'hfff;
      endcase
   endfunction

   // start stays high across back-to-back items; only one NBA per step
   task automatic send_item(req_item_type it);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   initial begin
      int unsigned ch;
      int unsigned n_stores;
      int unsigned style;
      int unsigned base;

      tracker    = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      items_sent = 0;
      calm       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty rings, bad channels, extremes, wrap-around, ties
      send_item(make_item(CMD_QUERY, 0, 4095));
      send_item(make_item(CMD_QUERY, 15, 0));
      send_item(make_item(CMD_STORE, 15, 4095));
      send_item(make_item(CMD_STORE, 12, 4095));
      send_item(make_item(CMD_QUERY, 12, 0));
      send_item(make_item(CMD_STORE, 0, 4095));
      send_item(make_item(CMD_STORE, 0, 0));
      send_item(make_item(CMD_QUERY, 0, 0));
      for (int i = 0; i < 9; i++)
         send_item(make_item(CMD_STORE, 11, (i % 3 == 0) ? 4095 : 12'h555));
      send_item(make_item(CMD_QUERY, 11, 12'haaa));
      send_item(make_item(CMD_STORE, 11, 0));
      send_item(make_item(CMD_QUERY, 11, 0));
      send_item(make_item(CMD_STORE, 5, 12'haaa));
      send_item(make_item(CMD_QUERY, 5, 0));
      send_item(make_item(CMD_STORE, 10, 12'h555));
      send_item(make_item(CMD_QUERY, 10, 0));

      // random: per-channel store runs ending in a query, with some noise
      while (items_sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_item(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                $urandom_range(0, 4095)));
         end else begin
            ch       = $urandom_range(0, CHANNELS - 1);
            n_stores = $urandom_range(0, 12);
            style    = $urandom_range(0, 4);
            base     = $urandom_range(0, 4095);
            for (int i = 0; i < n_stores; i++)
               send_item(make_item(CMD_STORE, ch, pick_sample(style, base)));
            if ($urandom_range(0, 4) == 0) ch = $urandom_range(0, CHANNELS - 1);
            send_item(make_item(CMD_QUERY, ch, $urandom_range(0, 4095)));
         end
      end
      start <= 1'b0;

      while (tracker.expected_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.check_drained();
      if (tracker.mismatches == 0)
         $display("tb_multichannel_median9_filter_core: done, clean");
      else
         $display("tb_multichannel_median9_filter_core: done, errors");
      $finish;
   end

endmodule

// ===== multichannel_median9_filter_core.f =====
rtl/mm9f_pkg.sv
rtl/mm9f_ctrl.sv
rtl/mm9f_dpath.sv
rtl/multichannel_median9_filter_core.sv
verif/tb_multichannel_median9_filter_core.sv
